// ----- src/temq_pkg.sv -----
// ----------------------------------------------------------------------------
// temq_pkg: shared types for the timed event queue
// Beat formats, stored entry, controller states and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package temq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int PEND_W          = 5;
  localparam int KEY_W           = 17;

  typedef struct packed {
    logic       mode;
    logic [7:0] client_id;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic              full_res;
    logic [7:0]        client_out;
    logic [4:0]        hour_out;
    logic [5:0]        minute_out;
    logic [5:0]        second_out;
    logic [PEND_W-1:0] pending;
  } rsp_t;

  typedef struct packed {
    logic [7:0] client;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic init;
    logic step;
    logic cmp;
    logic shift_init;
    logic move;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_mode;
    logic empty;
    logic idx_end;
    logic rd_vld;
    logic out_free;
  } status_t;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_NEXT = 1'b1;

  function automatic logic [KEY_W-1:0] time_key(input entry_t e);
    time_key = {e.hour, e.minute, e.second};
  endfunction

endpackage

// ----- src/temq_ctrl.sv -----
// ----------------------------------------------------------------------------
// temq_ctrl: sequencing for the timed event queue
// Steps one item through scan and compaction (non-empty next) to hand-off.
// ----------------------------------------------------------------------------
module temq_ctrl import temq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (status.in_mode == MODE_NEXT && !status.empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (status.idx_end && !status.rd_vld) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (status.idx_end && !status.rd_vld) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.init  = req_valid;
      end
      ST_SCAN: begin
        if (status.idx_end && !status.rd_vld) begin
          cmd.shift_init = 1'b1;
        end else begin
          cmd.step = 1'b1;
          cmd.cmp  = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd.step = 1'b1;
        cmd.move = 1'b1;
      end
      ST_RESP: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/temq_dp.sv -----
// ----------------------------------------------------------------------------
// temq_dp: entry store, scan comparator and result register
// Holds the entry memory and count, walks it for the earliest time, closes
// the gap after removal and drives the result beat.
// ----------------------------------------------------------------------------
module temq_dp import temq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  output rsp_t    rsp,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  input  cmd_t    cmd,
  output status_t status
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  entry_t          mem [QUEUE_DEPTH];
  req_t            hold;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;
  logic            rd_vld;
  entry_t          best;
  logic [AW-1:0]   best_idx;
  logic            idx_end;
  logic            full;
  logic            empty;
  logic            rd_go;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  entry_t          new_entry;
  logic            add_ok;
  logic            take_ok;
  rsp_t            rsp_next;

  assign idx_end = (idx >= count);
  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign rd_go   = cmd.step && !idx_end;

  assign new_entry = '{client: hold.client_id, hour: hold.hour_in,
                       minute: hold.minute_in, second: hold.second_in};

  assign add_ok  = cmd.commit && hold.mode == MODE_ADD && !full;
  assign take_ok = cmd.commit && hold.mode == MODE_NEXT && !empty;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = new_entry;
    if (cmd.move && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr - AW'(1);
      wr_data = rd_data;
    end else if (add_ok) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    rsp_next = '0;
    if (hold.mode == MODE_ADD) begin
      rsp_next.ok       = !full;
      rsp_next.full_res = full;
      rsp_next.pending  = full ? PEND_W'(count) : PEND_W'(count + CW'(1));
    end else if (!empty) begin
      rsp_next.ok         = 1'b1;
      rsp_next.client_out = best.client;
      rsp_next.hour_out   = best.hour;
      rsp_next.minute_out = best.minute;
      rsp_next.second_out = best.second;
      rsp_next.pending    = PEND_W'(count - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_go) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= rd_go;
      if (cmd.init) begin
        idx <= '0;
      end else if (cmd.shift_init) begin
        idx <= CW'(best_idx) + CW'(1);
      end else if (rd_go) begin
        idx <= idx + CW'(1);
      end
      if (add_ok) begin
        count <= count + CW'(1);
      end else if (take_ok) begin
        count <= count - CW'(1);
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      hold <= req;
    end
    if (rd_go) begin
      rd_addr <= idx[AW-1:0];
    end
    if (cmd.cmp && rd_vld) begin
      if (rd_addr == '0 || time_key(rd_data) < time_key(best)) begin
        best     <= rd_data;
        best_idx <= rd_addr;
      end
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  assign status = '{in_mode: req.mode, empty: empty, idx_end: idx_end,
                    rd_vld: rd_vld, out_free: !rsp_valid || !rsp_stall};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (CW'(rd_addr) < count))
    else $error("read beyond stored entries");

  a_take_dec: assert property (@(posedge clk) disable iff (rst)
    take_ok |=> count == $past(count) - CW'(1))
    else $error("removal did not decrement count");

  a_add_inc: assert property (@(posedge clk) disable iff (rst)
    add_ok |=> count == $past(count) + CW'(1))
    else $error("add did not increment count");

endmodule

// ----- src/timed_event_min_queue.sv -----
// ----------------------------------------------------------------------------
// timed_event_min_queue: bounded table of timed events, earliest out first
// Add, or next on an empty table: straight from accept to the result hand-off.
// Next on a non-empty table: a scan pass over all entries for the earliest
// time, then a compaction pass that moves each later entry down by one (none
// when the earliest is the last entry), then the hand-off; a new request is
// taken only after that. A stalled result beat holds the hand-off.
// Reset: synchronous; empties the table by clearing the count, no clearing pass.
// ----------------------------------------------------------------------------
module timed_event_min_queue import temq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  temq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  temq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
